// ----- rtl/fvt_pkg.sv -----
// ----------------------------------------------------------------------------
// fvt_pkg: shared definitions for the variable-tap FIR filter
// Field widths, action codes, default depth and sequencer state type.
// ----------------------------------------------------------------------------
package fvt_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEFF_W      = 16;
	localparam int ACC_W        = 40;
	localparam int TAPS_W       = 5;
	localparam int INDEX_W      = 4;
	localparam int FRAC_W       = 15;
	localparam int MAX_TAPS_DEF = 16;

	localparam logic ACTION_SAMPLE = 1'b0;
	localparam logic ACTION_COEFF  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_ROUND
	} fvt_state_t;

endpackage

// ----- rtl/fir_filter_variable_taps_unit.sv -----
// ----------------------------------------------------------------------------
// fir_filter_variable_taps_unit: direct-form FIR filter with run-time tap count
// One shared 16x16 multiply-accumulate unit walks the taps of each sample.
// ----------------------------------------------------------------------------
// A sample transfer passes through these steps before the next input
// transfer can be taken: the unit accepts and stores the sample, runs each
// tap on the single multiply-accumulate unit (its operands come from the
// coefficient and history memories, each with one registered read port),
// drains the last product, then rounds, saturates and loads the output
// register. A coefficient-write transfer is taken while idle and gives no
// result. The finished result sits in an output register, so the next sample
// is taken while an earlier result still waits; the unit only holds in its
// rounding step when that register is still full. Writing tap_count (saturated
// to 1..MAX_TAPS) clears the sample history and the write pointer; the
// configuration port is always ready and must only be used while the unit is
// idle. Sums are exact in 40 bits and rounded half up to Q1.15.
// ----------------------------------------------------------------------------
module fir_filter_variable_taps_unit #(
	parameter int MAX_TAPS = fvt_pkg::MAX_TAPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel (tap_count).
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [fvt_pkg::TAPS_W-1:0]         cfg_data,
	// Input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic signed [fvt_pkg::SAMPLE_W-1:0] sample,
	input  logic                               clear,
	input  logic [fvt_pkg::INDEX_W-1:0]        coeff_index,
	input  logic signed [fvt_pkg::COEFF_W-1:0] coeff_value,
	// Output channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fvt_pkg::SAMPLE_W-1:0] filtered_sample,
	output logic                               saturated
);
	import fvt_pkg::*;

	// Address width of the memories and width of the tap count register.
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int TW = $clog2(MAX_TAPS + 1);
	localparam int RW = SAMPLE_W + ACC_W - FRAC_W - SAMPLE_W; // rounded sum width
	localparam int PW = SAMPLE_W + COEFF_W;

	fvt_state_t state_q, state_d;

	logic [TW-1:0] tap_count_q;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] j_q;
	logic [MAX_TAPS-1:0] hist_vld_q;
	logic [MAX_TAPS-1:0] coef_vld_q;

	logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
	logic signed [COEFF_W-1:0]  coef_mem [MAX_TAPS];

	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic signed [COEFF_W-1:0]  coef_rd_s1;
	logic                       hist_v_s1;
	logic                       coef_v_s1;
	logic                       rd_v_s1;

	logic signed [ACC_W-1:0]    acc_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_sat_q;

	// Handshake and sequencer controls.
	logic in_acc;
	logic cfg_acc;
	logic smp_acc;
	logic coef_acc;
	logic rd_en;
	logic out_load;
	logic out_take;

	logic [AW-1:0] ptr_eff;
	logic [AW:0]   ptr_inc;
	logic [AW-1:0] ptr_next;
	logic [AW-1:0] tap_last;
	logic [TW-1:0] tap_new;

	logic signed [PW-1:0]    prod;
	logic signed [ACC_W-1:0] rnd_sum;
	logic signed [RW-1:0]    rnd_q;
	logic                    rnd_ovf;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign in_acc    = in_valid & ~in_stall;
	assign smp_acc   = in_acc & (action == ACTION_SAMPLE);
	assign coef_acc  = in_acc & (action == ACTION_COEFF)
		& (32'(coeff_index) < 32'(MAX_TAPS));
	assign out_take  = out_valid_q & ~out_stall;

	// Saturate the written tap count to 1..MAX_TAPS.
	always_comb begin
		if (cfg_data == '0) begin
			tap_new = TW'(1);
		end else if (32'(cfg_data) > 32'(MAX_TAPS)) begin
			tap_new = TW'(MAX_TAPS);
		end else begin
			tap_new = TW'(cfg_data);
		end
	end

	// A clear request restarts the history at entry zero.
	assign ptr_eff  = clear ? '0 : wr_ptr_q;
	assign ptr_inc  = {1'b0, ptr_eff} + 1'b1;
	assign ptr_next = (32'(ptr_inc) >= 32'(tap_count_q)) ? '0 : ptr_eff + 1'b1;
	assign tap_last = AW'(tap_count_q - 1'b1);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (k_q == tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_RUN:   rd_en    = 1'b1;
			ST_DRAIN: rd_en    = 1'b0;
			ST_ROUND: out_load = ~out_valid_q | ~out_stall;
			default:  in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tap count, write pointer and history valid bits. An entry whose valid
	// bit is low reads as zero, which stands in for clearing the memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TW'(1);
			wr_ptr_q    <= '0;
			hist_vld_q  <= '0;
		end else if (cfg_acc) begin
			tap_count_q <= tap_new;
			wr_ptr_q    <= '0;
			hist_vld_q  <= '0;
		end else if (smp_acc) begin
			wr_ptr_q   <= ptr_next;
			hist_vld_q <= (clear ? '0 : hist_vld_q) | (MAX_TAPS'(1) << ptr_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_acc) begin
			coef_vld_q[AW'(coeff_index)] <= 1'b1;
		end
	end

	// History and coefficient memories with registered reads.
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			hist_mem[ptr_eff] <= sample;
		end
		if (rd_en) begin
			hist_rd_s1 <= hist_mem[j_q];
		end
	end

	always_ff @(posedge clk) begin
		if (coef_acc) begin
			coef_mem[AW'(coeff_index)] <= coeff_value;
		end
		if (rd_en) begin
			coef_rd_s1 <= coef_mem[k_q];
		end
	end

	// Tap walk: k counts coefficients up, j steps back through the history.
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			k_q <= '0;
			j_q <= ptr_eff;
		end else if (rd_en) begin
			k_q <= k_q + 1'b1;
			j_q <= (j_q == '0) ? tap_last : j_q - 1'b1;
		end
		if (rd_en) begin
			hist_v_s1 <= hist_vld_q[j_q];
			coef_v_s1 <= coef_vld_q[k_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
		end
	end

	// Shared multiply-accumulate unit.
	assign prod = (hist_v_s1 && coef_v_s1) ? PW'(hist_rd_s1 * coef_rd_s1) : '0;

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			acc_q <= '0;
		end else if (rd_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod);
		end
	end

	// Round half up to Q1.15, then clip to the 16-bit range.
	assign rnd_sum = acc_q + ACC_W'(1 << (FRAC_W - 1));
	assign rnd_q   = rnd_sum[ACC_W-1:FRAC_W];
	assign rnd_ovf = (rnd_q[RW-1:SAMPLE_W-1] != '0) && (rnd_q[RW-1:SAMPLE_W-1] != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sat_q <= rnd_ovf;
			if (!rnd_ovf) begin
				out_sample_q <= rnd_q[SAMPLE_W-1:0];
			end else if (rnd_q[RW-1]) begin
				out_sample_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			end else begin
				out_sample_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_sample_q;
	assign saturated       = out_sat_q;

endmodule

// ----- tb/tb_fir_filter_variable_taps_unit.sv -----
// ----------------------------------------------------------------------------
// tb_fir_filter_variable_taps_unit: self-checking bench for the variable-tap FIR
// Items flow from a queue through a clocked driver into the filter. A built-in
// model predicts every filter output, and a clocked monitor compares each
// output transfer against the oldest prediction, field by field. The run goes
// through several tap counts and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_fir_filter_variable_taps_unit;
	import fvt_pkg::*;

	// Idle and stall patterns that a phase can run with.
	typedef enum {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// One input item, laid out like the input ports.
	typedef struct {
		logic                       action;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clear;
		logic [INDEX_W-1:0]         coeff_index;
		logic signed [COEFF_W-1:0]  coeff_value;
	} filter_item_t;

	// One filter output, laid out like the output ports.
	typedef struct {
		logic signed [SAMPLE_W-1:0] filtered_sample;
		logic                       saturated;
	} filter_output_t;

	localparam int CYCLE_LIMIT = 500_000;
	// Long enough for the slowest sample (16 taps) to finish.
	localparam int SETTLE_CYCLES = MAX_TAPS_DEF + 8;
	// Length of the long receiver hold-off that backs up the whole pipeline.
	localparam int HOLD_CYCLES = 400;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [TAPS_W-1:0]          cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       action = ACTION_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       clear = 1'b0;
	logic [INDEX_W-1:0]         coeff_index = '0;
	logic signed [COEFF_W-1:0]  coeff_value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] filtered_sample;
	logic                       saturated;

	fir_filter_variable_taps_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.sample          (sample),
		.clear           (clear),
		.coeff_index     (coeff_index),
		.coeff_value     (coeff_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered_sample (filtered_sample),
		.saturated       (saturated)
	);

	// Items waiting to be offered, and filter outputs still owed by the block.
	filter_item_t   pending_items[$];
	filter_output_t owed_outputs[$];

	idle_mode_t idle_mode = IDLE_NONE;
	int         error_count = 0;
	int         cycle_count = 0;
	// The sequencer bumps hold_requests; the stall process serves each request once.
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;

	// Filter state as the block should hold it.
	logic signed [SAMPLE_W-1:0] history_mem [MAX_TAPS_DEF];
	logic signed [COEFF_W-1:0]  coeff_mem [MAX_TAPS_DEF];
	int                         history_ptr = 0;
	int                         taps_in_use = 1;

	initial begin
		forever #5 clk = ~clk;
	end

	// Any run that takes this long has hung somewhere.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void clear_history();
		for (int i = 0; i < MAX_TAPS_DEF; i++) begin
			history_mem[i] = '0;
		end
		history_ptr = 0;
	endfunction

	// Applies one accepted item to the filter state. A sample item owes one
	// output: the exact sum of products over the taps in use, rounded half up
	// to Q1.15 and clipped to the 16-bit range.
	function automatic void filter_item_accepted(input filter_item_t item);
		longint         acc;
		longint         rounded;
		int             pos;
		filter_output_t result;
		acc = 0;
		if (item.action == ACTION_COEFF) begin
			coeff_mem[item.coeff_index] = item.coeff_value;
			return;
		end
		if (item.clear)
			clear_history();
		if (history_ptr >= taps_in_use)
			history_ptr = 0;
		history_mem[history_ptr] = item.sample;
		// Coefficient 0 goes with the newest sample; walk backward through history.
		pos = history_ptr;
		for (int k = 0; k < taps_in_use; k++) begin
			acc += longint'(coeff_mem[k]) * longint'(history_mem[pos]);
			pos = (pos == 0) ? taps_in_use - 1 : pos - 1;
		end
		history_ptr = (history_ptr + 1 >= taps_in_use) ? 0 : history_ptr + 1;
		// The arithmetic shift floors, which after adding one half rounds half up.
		rounded = (acc + 64'sd16384) >>> FRAC_W;
		result.saturated = 1'b1;
		if (rounded > 32767)
			result.filtered_sample = 16'sh7fff;
		else if (rounded < -32768)
			result.filtered_sample = 16'sh8000;
		else begin
			result.filtered_sample = rounded[SAMPLE_W-1:0];
			result.saturated = 1'b0;
		end
		owed_outputs.push_back(result);
	endfunction

	// Random Q1.15 value with a bias toward the extremes.
	function automatic logic signed [SAMPLE_W-1:0] random_q15();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// The fields a sample item does not use are filled with noise.
	function automatic filter_item_t make_sample(input logic signed [SAMPLE_W-1:0] value,
		input logic clr);
		filter_item_t item;
		item.action      = ACTION_SAMPLE;
		item.sample      = value;
		item.clear       = clr;
		item.coeff_index = INDEX_W'($urandom);
		item.coeff_value = COEFF_W'($urandom);
		return item;
	endfunction

	// Likewise for a coefficient write; its clear bit must have no effect.
	function automatic filter_item_t make_coeff(input logic [INDEX_W-1:0] idx,
		input logic signed [COEFF_W-1:0] value);
		filter_item_t item;
		item.action      = ACTION_COEFF;
		item.sample      = SAMPLE_W'($urandom);
		item.clear       = 1'($urandom);
		item.coeff_index = idx;
		item.coeff_value = value;
		return item;
	endfunction

	// Scaled-down coefficients keep many sums inside the output range.
	function automatic logic signed [COEFF_W-1:0] random_coeff();
		return random_q15() >>> $urandom_range(0, 5);
	endfunction

	function automatic bit sender_gap();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 79;
			IDLE_BOTH:   return $urandom_range(0, 99) < 34;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stall();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(0, 99) < 79;
			IDLE_BOTH:     return $urandom_range(0, 99) < 34;
			default:       return 1'b0;
		endcase
	endfunction

	// Input driver. An offered item stays on the ports unchanged until the
	// transfer happens; whether the next one is offered never looks at in_stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				filter_item_accepted(pending_items.pop_front());
			if (pending_items.size() != 0 && !sender_gap()) begin
				in_valid    <= 1'b1;
				action      <= pending_items[0].action;
				sample      <= pending_items[0].sample;
				clear       <= pending_items[0].clear;
				coeff_index <= pending_items[0].coeff_index;
				coeff_value <= pending_items[0].coeff_value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, including the long hold-off counted right here.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_stall();
		end
	end

	// Output monitor: every transfer must match the oldest owed output.
	always @(posedge clk) begin : check_outputs
		filter_output_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (owed_outputs.size() == 0) begin
				$error("unexpected output transfer: filtered_sample %0d, saturated %0b",
					filtered_sample, saturated);
				error_count++;
			end else begin
				want = owed_outputs.pop_front();
				if (filtered_sample !== want.filtered_sample) begin
					$error("filtered_sample: expected %0d, got %0d",
						want.filtered_sample, filtered_sample);
					error_count++;
				end
				if (saturated !== want.saturated) begin
					$error("saturated: expected %0b, got %0b", want.saturated, saturated);
					error_count++;
				end
			end
		end
	end

	// Waits until every item is taken and every owed output has come, then lets
	// the block finish any trailing coefficient write before it is touched.
	task automatic wait_until_idle();
		while (pending_items.size() != 0 || in_valid || owed_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes tap_count; the block clips it to 1..MAX_TAPS and drops its history.
	task automatic write_tap_count(input logic [TAPS_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (value < 1)
			taps_in_use = 1;
		else if (value > MAX_TAPS_DEF)
			taps_in_use = MAX_TAPS_DEF;
		else
			taps_in_use = value;
		clear_history();
	endtask

	// One random phase: a fresh coefficient set for the taps in use, then a mix
	// that is mostly samples, with coefficient rewrites (also of unused taps),
	// the odd history clear and some fully random items.
	task automatic run_phase(input logic [TAPS_W-1:0] taps_value, input idle_mode_t mode,
		input int count, input bit long_hold);
		int pick;
		wait_until_idle();
		write_tap_count(taps_value);
		idle_mode = mode;
		for (int k = 0; k < taps_in_use; k++) begin
			pending_items.push_back(make_coeff(INDEX_W'(k), random_coeff()));
		end
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 78)
				pending_items.push_back(make_sample(random_q15(), 1'b0));
			else if (pick < 81)
				pending_items.push_back(make_sample(random_q15(), 1'b1));
			else if (pick < 96)
				pending_items.push_back(make_coeff(INDEX_W'($urandom), random_coeff()));
			else if ($urandom_range(0, 1) == 0)
				pending_items.push_back(make_sample(SAMPLE_W'($urandom), 1'($urandom)));
			else
				pending_items.push_back(make_coeff(INDEX_W'($urandom), COEFF_W'($urandom)));
		end
		// With the sender still offering items, this backs the block up until it
		// stalls its input.
		if (long_hold)
			hold_requests++;
	endtask

	initial begin
		for (int i = 0; i < MAX_TAPS_DEF; i++) begin
			coeff_mem[i] = '0;
		end
		clear_history();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset tap count of one. All coefficients start at
		// zero, so the first sample must give zero.
		pending_items.push_back(make_sample(16'sd12345, 1'b0));
		pending_items.push_back(make_coeff(4'd0, 16'sh7fff));
		pending_items.push_back(make_sample(16'sh7fff, 1'b0));
		pending_items.push_back(make_sample(16'sh8000, 1'b0));
		// Most negative times most negative rounds to +1.0 and has to clip.
		pending_items.push_back(make_coeff(4'd0, 16'sh8000));
		pending_items.push_back(make_sample(16'sh8000, 1'b0));
		pending_items.push_back(make_sample(16'sh0000, 1'b0));
		// A coefficient write with clear set must leave the history alone; tap 15
		// is stored but unused at this tap count.
		pending_items.push_back('{ACTION_COEFF, 16'sh7fff, 1'b1, 4'd15, 16'sh7fff});
		pending_items.push_back(make_sample(16'sh0001, 1'b1));
		// A half coefficient puts exact halves on the rounding point: they round up.
		pending_items.push_back(make_coeff(4'd0, 16'sh4000));
		pending_items.push_back(make_sample(16'sh0001, 1'b0));
		pending_items.push_back(make_sample(16'shffff, 1'b0));
		wait_until_idle();

		// Two taps at full scale drive the sum below the range.
		write_tap_count(5'd2);
		pending_items.push_back(make_coeff(4'd1, 16'sh7fff));
		pending_items.push_back(make_coeff(4'd0, 16'sh7fff));
		pending_items.push_back(make_sample(16'sh8000, 1'b0));
		pending_items.push_back(make_sample(16'sh8000, 1'b0));
		pending_items.push_back(make_sample(16'sh7fff, 1'b1));
		pending_items.push_back(make_sample(16'sh7fff, 1'b0));
		wait_until_idle();

		// A tap count of zero is clipped to one, keeping the coefficients.
		write_tap_count(5'd0);
		pending_items.push_back(make_sample(16'sh7fff, 1'b0));
		pending_items.push_back(make_sample(16'sh8000, 1'b0));

		// Random phases; the clipped values 31 and 17 stand for the largest size.
		run_phase(5'd16, IDLE_NONE, 200, 1'b0);
		run_phase(5'd31, IDLE_SENDER, 190, 1'b0);
		run_phase(5'd1, IDLE_RECEIVER, 150, 1'b0);
		run_phase(5'd5, IDLE_BOTH, 200, 1'b0);
		run_phase(5'd17, IDLE_NONE, 200, 1'b1);
		run_phase(TAPS_W'($urandom_range(1, 16)), IDLE_RECEIVER, 200, 1'b0);
		run_phase(TAPS_W'($urandom_range(2, 16)), IDLE_SENDER, 200, 1'b0);
		run_phase(5'd3, IDLE_BOTH, 200, 1'b0);
		wait_until_idle();

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/fvt_pkg.sv
rtl/fir_filter_variable_taps_unit.sv
tb/tb_fir_filter_variable_taps_unit.sv
